// ===== rtl/dcc_pkg.sv =====
package dcc_pkg;

    localparam int STEP_TOTAL   = 31;   // quotient bits 31..1
    localparam int UNS_STEPS    = 15;
    localparam int QLOW_STEP    = 16;   // first step that yields quotient bit 15
    localparam int STEP_IDX_W   = 5;

    localparam logic [7:0] UNS_BASE     = 8'(36 << 1);
    localparam logic [7:0] SGN_BASE     = 8'd53;
    localparam logic [7:0] SGN_NEG_OFS  = 8'd7;
    localparam logic [7:0] SGN_POS_OFS  = 8'd6;
    localparam logic [7:0] UNS_SUB_ADD  = 8'd2;
    localparam logic [7:0] UNS_FAIL_ADD = 8'd4;

    typedef logic [STEP_IDX_W-1:0] step_idx_t;

    // In unsigned mode work is the working dividend; in signed mode work
    // shifts the dividend magnitude out while rem holds the remainder.
    typedef struct packed {
        logic        kind;
        logic        dz;
        logic [15:0] rem;
        logic [31:0] work;
        logic [15:0] dvs;
        logic [7:0]  count;
    } dcc_data_t;

    function automatic dcc_data_t dcc_step(dcc_data_t d, step_idx_t idx);
        dcc_data_t   r;
        logic [31:0] sh;
        logic [16:0] t;
        logic [16:0] diff;
        r = d;
        if (!d.kind) begin
            if (32'(idx) < UNS_STEPS) begin
                sh = d.work << 1;
                if (d.work[31]) begin
                    r.work = {sh[31:16] - d.dvs, sh[15:0]};
                end
                else if (sh[31:16] >= d.dvs) begin
                    r.work  = {sh[31:16] - d.dvs, sh[15:0]};
                    r.count = d.count + UNS_SUB_ADD;
                end
                else begin
                    r.work  = sh;
                    r.count = d.count + UNS_FAIL_ADD;
                end
            end
        end
        else begin
            t      = {d.rem, d.work[31]};
            diff   = t - {1'b0, d.dvs};
            r.work = d.work << 1;
            if (t >= {1'b0, d.dvs}) begin
                r.rem = diff[15:0];
            end
            else begin
                r.rem = t[15:0];
                if (32'(idx) >= QLOW_STEP) begin
                    r.count = d.count + 8'd1;
                end
            end
        end
        return r;
    endfunction

endpackage

// ===== rtl/dcc_prep.sv =====
module dcc_prep (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              kind,
    input  logic [31:0]       dividend,
    input  logic [15:0]       divisor,
    output logic              out_valid,
    input  logic              out_ready,
    output dcc_pkg::dcc_data_t out_data
);
    import dcc_pkg::*;

    logic      valid_reg;
    dcc_data_t data_reg;
    dcc_data_t data_next;
    logic      dvd_neg;
    logic      dvs_neg;
    logic [7:0] sbase;

    assign dvd_neg = dividend[31];
    assign dvs_neg = divisor[15];

    always_comb
    begin
        sbase = (dvd_neg ? SGN_NEG_OFS : SGN_POS_OFS) + SGN_BASE;
        if (!dvs_neg) begin
            sbase = dvd_neg ? sbase + 8'd1 : sbase - 8'd1;
        end
        data_next.kind = kind;
        data_next.rem  = '0;
        if (!kind) begin
            data_next.dz    = 1'b0;
            data_next.work  = dividend;
            data_next.dvs   = divisor;
            data_next.count = UNS_BASE;
        end
        else begin
            data_next.dz    = (divisor == 16'd0);
            data_next.work  = dvd_neg ? 32'd0 - dividend : dividend;
            data_next.dvs   = dvs_neg ? 16'd0 - divisor : divisor;
            data_next.count = sbase;
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== rtl/dcc_stage.sv =====
module dcc_stage #(
    parameter int FIRST_STEP = 0,
    parameter int STEPS      = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  dcc_pkg::dcc_data_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output dcc_pkg::dcc_data_t out_data
);
    import dcc_pkg::*;

    logic      valid_reg;
    dcc_data_t data_reg;
    dcc_data_t data_next;

    // steps past the last quotient bit pass the beat through unchanged
    always_comb
    begin
        data_next = in_data;
        for (int k = 0; k < STEPS; k++) begin
            if (FIRST_STEP + k < STEP_TOTAL) begin
                data_next = dcc_step(data_next, step_idx_t'(FIRST_STEP + k));
            end
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== rtl/dcc_out.sv =====
module dcc_out (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  dcc_pkg::dcc_data_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         cycles,
    output logic               divide_by_zero
);
    import dcc_pkg::*;

    logic       valid_reg;
    logic [7:0] cycles_reg;
    logic [7:0] cycles_next;
    logic       dz_reg;

    always_comb
    begin
        if (!in_data.kind) begin
            cycles_next = in_data.count;
        end
        else if (in_data.dz) begin
            cycles_next = 8'd0;
        end
        else begin
            cycles_next = in_data.count << 1;
        end
    end

    assign in_ready       = !valid_reg || out_ready;
    assign out_valid      = valid_reg;
    assign cycles         = cycles_reg;
    assign divide_by_zero = dz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid) begin
            cycles_reg <= cycles_next;
            dz_reg     <= in_data.dz;
        end
    end

endmodule

// ===== rtl/divide_cycle_count.sv =====
// A beat passes through the prep register, the step stages and the output register in that order.
// Throughput: one beat per cycle while out_ready allows; each stage holds one beat and fills when the next drains.
// Depth is set by the 31 restoring-divide steps, STEPS_PER_STAGE of them per register stage.
// Reset (rst_n, async, active low) clears every stage valid bit; payload is not reset.
module divide_cycle_count #(
    parameter int STEPS_PER_STAGE = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        kind,
    input  logic [31:0] dividend,
    input  logic [15:0] divisor,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  cycles,
    output logic        divide_by_zero
);
    import dcc_pkg::*;

    localparam int NSTAGE = (STEP_TOTAL + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

    dcc_data_t pipe_data  [NSTAGE+1];
    logic      pipe_valid [NSTAGE+1];
    logic      pipe_ready [NSTAGE+1];

    dcc_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .kind      (kind),
        .dividend  (dividend),
        .divisor   (divisor),
        .out_valid (pipe_valid[0]),
        .out_ready (pipe_ready[0]),
        .out_data  (pipe_data[0])
    );

    for (genvar i = 0; i < NSTAGE; i++) begin : g_stage
        dcc_stage #(
            .FIRST_STEP (i * STEPS_PER_STAGE),
            .STEPS      (STEPS_PER_STAGE)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (pipe_valid[i]),
            .in_ready  (pipe_ready[i]),
            .in_data   (pipe_data[i]),
            .out_valid (pipe_valid[i+1]),
            .out_ready (pipe_ready[i+1]),
            .out_data  (pipe_data[i+1])
        );
    end

    dcc_out u_out (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (pipe_valid[NSTAGE]),
        .in_ready       (pipe_ready[NSTAGE]),
        .in_data        (pipe_data[NSTAGE]),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .cycles         (cycles),
        .divide_by_zero (divide_by_zero)
    );

endmodule

// ===== rtl/dcc_chk.sv =====
module dcc_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  cycles,
    input logic        divide_by_zero
);

    // valid bits are cleared asynchronously by rst_n, so the check looks at the next edge
    a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("result beat shown during reset");

    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && divide_by_zero |-> cycles == 8'd0)
        else $error("zero divisor flagged with nonzero cycle count");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !divide_by_zero |-> cycles >= 8'd72 && cycles <= 8'd152)
        else $error("cycle count out of range");

    a_even: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !cycles[0])
        else $error("odd cycle count");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(cycles) && $stable(divide_by_zero))
        else $error("stalled result beat changed");

endmodule

bind divide_cycle_count dcc_chk u_dcc_chk (.*);

// ===== tb/tb_top.sv =====
module tb_top;

    localparam bit KIND_UNSIGNED = 1'b0;
    localparam bit KIND_SIGNED   = 1'b1;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int TAIL_CYCLES   = 30;
    localparam int REPORT_MAX    = 10;
    localparam int RANDOM_ITEMS  = 530;

    typedef struct {
        bit        kind;
        bit [31:0] dividend;
        bit [15:0] divisor;
        bit        drain;     // hold off until every result is back
    } div_req_t;

    typedef struct packed {
        logic [7:0] cycles;
        logic       dz;
    } div_timing_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        kind;
    logic [31:0] dividend;
    logic [15:0] divisor;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  cycles;
    logic        divide_by_zero;

    div_req_t    pending[$];
    div_timing_t results_due[$];
    logic        in_beat;
    int          errors;
    int          cycle_count;
    int          send_gap;
    int          send_calm;
    int          stall_left;
    int          recv_calm;

    divide_cycle_count uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .kind           (kind),
        .dividend       (dividend),
        .divisor        (divisor),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .cycles         (cycles),
        .divide_by_zero (divide_by_zero)
    );

    always #1 clk = ~clk;

    // Cycle cost of one divide request.
    function automatic div_timing_t divide_timing(bit k, bit [31:0] dvd, bit [15:0] dvs);
        div_timing_t     t;
        bit [31:0]       work;
        bit [31:0]       hdiv;
        bit [31:0]       mag_dvd;
        bit [15:0]       mag_dvs;
        bit [31:0]       quot;
        bit              top;
        int unsigned     count;
        t.dz = 1'b0;
        if (k == KIND_UNSIGNED)
        begin
            hdiv  = {dvs, 16'h0000};
            work  = dvd;
            count = 72;
            for (int i = 0; i < 15; i++)
            begin
                top  = work[31];
                work = work << 1;
                if (top)
                    work = work - hdiv;
                else if (work >= hdiv)
                begin
                    work  = work - hdiv;
                    count = count + 2;
                end
                else
                    count = count + 4;
            end
            t.cycles = 8'(count);
        end
        else if (dvs == 16'h0000)
        begin
            t.cycles = 8'd0;
            t.dz     = 1'b1;
        end
        else
        begin
            count = dvd[31] ? 60 : 59;
            if (!dvs[15])
                count = dvd[31] ? count + 1 : count - 1;
            mag_dvd = dvd[31] ? (32'd0 - dvd) : dvd;
            mag_dvs = dvs[15] ? (16'd0 - dvs) : dvs;
            quot    = mag_dvd / {16'h0000, mag_dvs};
            // quotient bits 15..1: each clear bit adds one to the count
            for (int i = 15; i >= 1; i--)
                if (!quot[i])
                    count = count + 1;
            t.cycles = 8'(count << 1);
        end
        return t;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 1;
        else if (r < 85)
            return $urandom_range(2, 4);
        else if (r < 96)
            return $urandom_range(5, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic add_req(bit k, bit [31:0] dvd, bit [15:0] dvs, bit drain);
        div_req_t req;
        req.kind     = k;
        req.dividend = dvd;
        req.divisor  = dvs;
        req.drain    = drain;
        pending.push_back(req);
    endtask

    task automatic add_random_req(bit drain);
        bit [15:0] dvs;
        bit [15:0] mag_dvs;
        bit [31:0] mag;
        bit [31:0] corner_dvd[6];
        bit [15:0] corner_dvs[6];
        int        r;
        corner_dvd = '{32'h0000_0000, 32'h0000_0001, 32'h7FFF_FFFF,
                       32'h8000_0000, 32'h8000_0001, 32'hFFFF_FFFF};
        corner_dvs = '{16'h0000, 16'h0001, 16'h7FFF, 16'h8000, 16'h8001, 16'hFFFF};
        r = $urandom_range(0, 99);
        if (r < 15)
            add_req(1'($urandom), $urandom, 16'($urandom), drain);
        else if (r < 45)
        begin
            // unsigned divide whose quotient fits in 16 bits
            dvs = 16'($urandom_range(1, 65535));
            add_req(KIND_UNSIGNED, {16'($urandom_range(0, dvs - 1)), 16'($urandom)}, dvs,
                    drain);
        end
        else if (r < 80)
        begin
            // signed divide whose magnitude quotient fits in 15 bits
            dvs     = 16'($urandom_range(1, 65535));
            mag_dvs = dvs[15] ? (16'd0 - dvs) : dvs;
            mag     = $urandom_range(0, 32767) * mag_dvs + $urandom_range(0, mag_dvs - 1);
            add_req(KIND_SIGNED, $urandom_range(0, 1) ? (32'd0 - mag) : mag, dvs, drain);
        end
        else if (r < 93)
            add_req(1'($urandom), corner_dvd[$urandom_range(0, 5)],
                    corner_dvs[$urandom_range(0, 5)], drain);
        else
            add_req(1'($urandom), $urandom, 16'h0000, drain);
    endtask

    task automatic report(string msg);
        errors++;
        if (errors <= REPORT_MAX)
            $display("%s", msg);
    endtask

    // request side
    always @(negedge clk)
    begin
        div_req_t req;
        if (rst_n && (!in_valid || in_beat))
        begin
            if (send_gap != 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (pending.size() != 0 && !(pending[0].drain && results_due.size() != 0))
            begin
                req = pending.pop_front();
                kind     <= req.kind;
                dividend <= req.dividend;
                divisor  <= req.divisor;
                in_valid <= 1'b1;
                if (send_calm != 0)
                begin
                    send_calm--;
                    send_gap = 0;
                end
                else
                begin
                    send_gap = $urandom_range(0, 1) ? 0 : pick_gap();
                    if ($urandom_range(0, 49) == 0)
                        send_calm = $urandom_range(20, 60);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result side backpressure
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left != 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (recv_calm != 0)
                    recv_calm--;
                else if ($urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
                else if ($urandom_range(0, 39) == 0)
                    recv_calm = $urandom_range(20, 80);
            end
        end
    end

    always @(posedge clk)
    begin
        div_timing_t exp_t;
        if (rst_n)
        begin
            in_beat <= in_valid && in_ready;
            if (in_valid && in_ready)
                results_due.push_back(divide_timing(kind, dividend, divisor));
            if (out_valid && out_ready)
            begin
                if (results_due.size() == 0)
                    report($sformatf("unexpected result beat: cycles %0d dz %0b",
                                     cycles, divide_by_zero));
                else
                begin
                    exp_t = results_due.pop_front();
                    if (cycles !== exp_t.cycles)
                        report($sformatf("cycles mismatch: expected %0d, got %0d",
                                         exp_t.cycles, cycles));
                    if (divide_by_zero !== exp_t.dz)
                        report($sformatf("divide_by_zero mismatch: expected %0b, got %0b",
                                         exp_t.dz, divide_by_zero));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        kind        = KIND_UNSIGNED;
        dividend    = 32'h0;
        divisor     = 16'h0;
        out_ready   = 1'b0;
        in_beat     = 1'b0;
        errors      = 0;
        cycle_count = 0;
        send_gap    = 0;
        send_calm   = 0;
        stall_left  = 0;
        recv_calm   = 0;

        // unsigned: zero divisor, overflow, max quotient, top bit set
        add_req(KIND_UNSIGNED, 32'h0000_0000, 16'h0000, 1'b0);
        add_req(KIND_UNSIGNED, 32'hFFFF_FFFF, 16'h0000, 1'b0);
        add_req(KIND_UNSIGNED, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
        add_req(KIND_UNSIGNED, 32'h8000_0000, 16'h0001, 1'b0);
        add_req(KIND_UNSIGNED, 32'h7FFF_FFFF, 16'hFFFF, 1'b0);
        add_req(KIND_UNSIGNED, 32'h0000_0000, 16'h0001, 1'b0);
        add_req(KIND_UNSIGNED, 32'hFFFE_0001, 16'hFFFF, 1'b0);
        add_req(KIND_UNSIGNED, 32'h0001_0000, 16'h0001, 1'b0);
        add_req(KIND_UNSIGNED, 32'h0000_FFFF, 16'h8000, 1'b0);
        // signed: zero divisor, most negative magnitudes, every sign pairing
        add_req(KIND_SIGNED, 32'h1234_5678, 16'h0000, 1'b0);
        add_req(KIND_SIGNED, 32'h8000_0000, 16'h0000, 1'b0);
        add_req(KIND_SIGNED, 32'h8000_0000, 16'h8000, 1'b0);
        add_req(KIND_SIGNED, 32'h8000_0000, 16'h0001, 1'b0);
        add_req(KIND_SIGNED, 32'h7FFF_FFFF, 16'h7FFF, 1'b0);
        add_req(KIND_SIGNED, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
        add_req(KIND_SIGNED, 32'h0000_0000, 16'h8000, 1'b0);
        add_req(KIND_SIGNED, 32'h0000_0000, 16'h0001, 1'b0);
        add_req(KIND_SIGNED, 32'hFFFF_8000, 16'h0001, 1'b0);
        add_req(KIND_SIGNED, 32'h0000_7FFF, 16'hFFFF, 1'b0);
        add_req(KIND_SIGNED, 32'h3FFF_8001, 16'h7FFF, 1'b0);
        add_req(KIND_SIGNED, 32'hC000_7FFF, 16'h8001, 1'b0);
        add_req(KIND_SIGNED, 32'h0000_AAAA, 16'h0001, 1'b0);
        for (int i = 0; i < RANDOM_ITEMS; i++)
            add_random_req(i == 150 || i == 400 || $urandom_range(0, 99) == 0);

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending.size() != 0 || in_valid || results_due.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
